@@ rtl/gfmk_pkg.sv @@
// shared constants for the gf(2^128) multiply-by-key pipeline
package gfmk_pkg;

	localparam int BLOCK_W = 128;
	localparam int WORD_W  = 64;

	// bits of the operand consumed by one cell
	localparam int DIGIT_W = 8;

	// x^128 = 1 + x + x^2 + x^7
	localparam int RED_TAP_A = 1;
	localparam int RED_TAP_B = 2;
	localparam int RED_TAP_C = 7;

	localparam int CFG_INDEX_W = 2;
	localparam logic [CFG_INDEX_W-1:0] REG_KEY_LOW  = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_KEY_HIGH = 2'd1;

endpackage

@@ rtl/gfmk_if.sv @@
// valid/ready channels for operand blocks and products
interface gfmk_block_if;
	import gfmk_pkg::*;
	logic              valid;
	logic              ready;
	logic [WORD_W-1:0] block_low;
	logic [WORD_W-1:0] block_high;

	modport source (output valid, output block_low, output block_high, input ready);
	modport sink (input valid, input block_low, input block_high, output ready);
endinterface

interface gfmk_product_if;
	import gfmk_pkg::*;
	logic              valid;
	logic              ready;
	logic [WORD_W-1:0] product_low;
	logic [WORD_W-1:0] product_high;

	modport source (output valid, output product_low, output product_high, input ready);
	modport sink (input valid, input product_low, input product_high, output ready);
endinterface

@@ rtl/gfmk_cell.sv @@
// one pipeline cell: acc = acc * x^D + digit * H, reduced mod the gcm polynomial
module gfmk_cell
	import gfmk_pkg::*;
#(
	parameter int DIGIT = DIGIT_W
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [BLOCK_W-1:0] in_acc,
	input  logic [BLOCK_W-1:0] in_x,
	input  logic [BLOCK_W-1:0] key,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [BLOCK_W-1:0] out_acc,
	output logic [BLOCK_W-1:0] out_x
);

	logic               valid_q;
	logic [BLOCK_W-1:0] acc_q;
	logic [BLOCK_W-1:0] x_q;

	logic [BLOCK_W+DIGIT-1:0] wide;
	logic [DIGIT-1:0]         dig;
	logic [BLOCK_W-1:0]       ov_ext;
	logic [BLOCK_W-1:0]       acc_nxt;

	assign in_ready = !valid_q || out_ready;

	always_comb begin
		dig  = in_x[BLOCK_W-1 -: DIGIT];
		wide = {in_acc, {DIGIT{1'b0}}};
		for (int j = 0; j < DIGIT; j++) begin
			if (dig[j]) begin
				wide = wide ^ ({{DIGIT{1'b0}}, key} << j);
			end
		end
		// fold the bits above x^127 back once; the fold itself stays below x^128
		ov_ext  = {{(BLOCK_W-DIGIT){1'b0}}, wide[BLOCK_W+DIGIT-1 -: DIGIT]};
		acc_nxt = wide[BLOCK_W-1:0] ^ ov_ext ^ (ov_ext << RED_TAP_A)
			^ (ov_ext << RED_TAP_B) ^ (ov_ext << RED_TAP_C);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			acc_q <= acc_nxt;
			x_q   <= in_x << DIGIT;
		end
	end

	assign out_valid = valid_q;
	assign out_acc   = acc_q;
	assign out_x     = x_q;

endmodule

@@ rtl/gf128_multiply_by_key.sv @@
// gf(2^128) multiply by key: a chain of BLOCK_W/DIGIT cells, msb digit first
// each cell consumes one digit of X and hands on its sum, registered, to the next cell
// throughput: one block per cycle while the output is not stalled
// a stalled output holds the last cell, earlier cells keep filling any empty slots
// reset clears all cell valid bits and both key registers to zero
module gf128_multiply_by_key
	import gfmk_pkg::*;
#(
	parameter int DIGIT = DIGIT_W
) (
	input  logic                   clk,
	input  logic                   arst_n,
	gfmk_block_if.sink             blk,
	gfmk_product_if.source         prod,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [WORD_W-1:0]      cfg_data
);

	localparam int NUM_CELLS = BLOCK_W / DIGIT;

	logic [WORD_W-1:0] key_low_q;
	logic [WORD_W-1:0] key_high_q;
	logic [BLOCK_W-1:0] key;

	logic               vld_c [NUM_CELLS+1];
	logic               rdy_c [NUM_CELLS+1];
	logic [BLOCK_W-1:0] acc_c [NUM_CELLS+1];
	logic [BLOCK_W-1:0] x_c   [NUM_CELLS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_low_q  <= '0;
			key_high_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_KEY_LOW:  key_low_q  <= cfg_data;
				REG_KEY_HIGH: key_high_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign key = {key_high_q, key_low_q};

	assign vld_c[0] = blk.valid;
	assign blk.ready = rdy_c[0];
	assign acc_c[0] = '0;
	assign x_c[0]   = {blk.block_high, blk.block_low};

	for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
		gfmk_cell #(
			.DIGIT(DIGIT)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (vld_c[i]),
			.in_ready (rdy_c[i]),
			.in_acc   (acc_c[i]),
			.in_x     (x_c[i]),
			.key      (key),
			.out_valid(vld_c[i+1]),
			.out_ready(rdy_c[i+1]),
			.out_acc  (acc_c[i+1]),
			.out_x    (x_c[i+1])
		);
	end

	assign rdy_c[NUM_CELLS] = prod.ready;
	assign prod.valid        = vld_c[NUM_CELLS];
	assign prod.product_low  = acc_c[NUM_CELLS][WORD_W-1:0];
	assign prod.product_high = acc_c[NUM_CELLS][BLOCK_W-1:WORD_W];

endmodule

@@ rtl/gfmk_checker.sv @@
// port-level checks for the multiply-by-key pipeline, bound to the top level
module gfmk_checker
	import gfmk_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              blk_valid,
	input logic              blk_ready,
	input logic              prod_valid,
	input logic              prod_ready,
	input logic [WORD_W-1:0] product_low,
	input logic [WORD_W-1:0] product_high
);

	// stalled product beat holds its value
	a_prod_hold: assert property (@(posedge clk) disable iff (!arst_n)
		prod_valid && !prod_ready |=> prod_valid && $stable(product_low)
			&& $stable(product_high))
		else $error("product changed while stalled");

	// with the last cell empty the whole chain can take a beat
	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!prod_valid |-> blk_ready)
		else $error("input stalled with empty output");

	// nothing comes out of a freshly reset pipeline
	a_reset_empty: assert property (@(posedge clk)
		!$past(arst_n) |-> !prod_valid)
		else $error("product valid right after reset");

	// a beat offered while the last cell is empty is accepted at once
	a_take_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		blk_valid && !prod_valid |-> blk_ready)
		else $error("offered beat refused with empty output");

endmodule

bind gf128_multiply_by_key gfmk_checker u_gfmk_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.blk_valid   (blk.valid),
	.blk_ready   (blk.ready),
	.prod_valid  (prod.valid),
	.prod_ready  (prod.ready),
	.product_low (prod.product_low),
	.product_high(prod.product_high)
);
